// ===== hdl/typed_message_deframer_defines.svh =====
// Assertion macros for the typed message deframer checker.
`ifndef TYPED_MESSAGE_DEFRAMER_DEFINES_SVH
`define TYPED_MESSAGE_DEFRAMER_DEFINES_SVH

// Checked only while out of reset.
`define TMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define TMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/tmd_pkg.sv =====
// Shared constants, types and helpers of the typed message deframer.
`default_nettype none
package tmd_pkg;

  localparam int unsigned MAX_MESSAGE  = 1024;
  localparam int unsigned CHECK_OFFSET = 6;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned CNT_W  = $clog2(MAX_MESSAGE);

  localparam logic [CNT_W-1:0] POS_CAP   = CNT_W'(MAX_MESSAGE - 1);
  localparam logic [CNT_W-1:0] CHECK_POS = CNT_W'(CHECK_OFFSET);

  localparam logic [BYTE_W-1:0] BYTE_PACKET  = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_ETX     = 8'h03;
  localparam logic [BYTE_W-1:0] BYTE_READY   = 8'h04;
  localparam logic [BYTE_W-1:0] BYTE_IDLE    = 8'h05;
  localparam logic [BYTE_W-1:0] BYTE_STATUS  = 8'h10;
  localparam logic [BYTE_W-1:0] BYTE_ERROR   = 8'h15;
  localparam logic [BYTE_W-1:0] BYTE_ETB     = 8'h17;
  localparam logic [BYTE_W-1:0] BYTE_SHORT   = 8'hfe;

  typedef enum logic [KIND_W-1:0] {
    KIND_READY  = 3'd0,
    KIND_IDLE   = 3'd1,
    KIND_ERROR  = 3'd2,
    KIND_STATUS = 3'd3,
    KIND_PACKET = 3'd4,
    KIND_DATA   = 3'd5,
    KIND_NONE   = 3'd7
  } kind_e;

  // Input register contents handed to the decode stage.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } stage_t;

  function automatic kind_e classify(input logic [BYTE_W-1:0] b);
    kind_e k;
    case (b)
      BYTE_READY:  k = KIND_READY;
      BYTE_IDLE:   k = KIND_IDLE;
      BYTE_ERROR:  k = KIND_ERROR;
      BYTE_STATUS: k = KIND_STATUS;
      BYTE_PACKET: k = KIND_PACKET;
      default:     k = KIND_DATA;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tmd_if.sv =====
// Byte and result channel interfaces of the typed message deframer.
`default_nettype none
interface tmd_byte_if;
  import tmd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tmd_result_if;
  import tmd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] message_kind;
  logic [POS_W-1:0]  position;
  logic              message_start;
  logic              message_end;
  logic              checksum_good;
  logic              overflow;

  modport source (output valid, output out_byte, output message_kind, output position,
                  output message_start, output message_end, output checksum_good,
                  output overflow, input ready);
  modport sink   (input valid, input out_byte, input message_kind, input position,
                  input message_start, input message_end, input checksum_good,
                  input overflow, output ready);
endinterface
`default_nettype wire

// ===== hdl/typed_message_deframer.sv =====
// Typed message deframer: takes one byte per cycle while the result is not
// stalled and returns each byte tagged with its message kind, position,
// start/end marks, checksum result and overflow. A byte passes through the
// input register and then the result register, with the message state
// updated between them. Ready is combinational from the output ready through
// the two register stages, so a stalled result holds both stages in place.
`default_nettype none
module typed_message_deframer (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  tmd_byte_if.sink     in_i,
  tmd_result_if.source out_o
);
  import tmd_pkg::*;

  stage_t stage;
  logic   advance;

  tmd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  tmd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_o (advance),
    .out_o     (out_o)
  );
endmodule
`default_nettype wire

// ===== hdl/tmd_in_stage.sv =====
// Input register: captures one byte request and holds it until decode takes it.
`default_nettype none
module tmd_in_stage (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tmd_byte_if.sink      in_i,
  input  wire logic     advance_i,
  output tmd_pkg::stage_t stage_o
);
  import tmd_pkg::*;

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] data_q;
  logic              in_fire;

  // Free slot, or the held byte moves on this cycle.
  assign in_i.ready = !valid_q || advance_i;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= in_i.data_byte;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;
endmodule
`default_nettype wire

// ===== hdl/tmd_decode.sv =====
// Message state machine and result register.
`default_nettype none
module tmd_decode (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire tmd_pkg::stage_t stage_i,
  output logic            advance_o,
  tmd_result_if.source    out_o
);
  import tmd_pkg::*;

  kind_e             kind_q, kind_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic              await_q, await_d;
  logic              exceed_q, exceed_d;

  kind_e             kind;
  logic [CNT_W-1:0]  pos;
  logic              start, fin, good, ovf;
  logic [BYTE_W-1:0] expect_sum;
  logic [BYTE_W-1:0] b;

  logic              out_valid_q;
  logic              fire;

  assign advance_o = !out_valid_q || out_o.ready;
  assign fire      = stage_i.valid && advance_o;
  assign b         = stage_i.data;

  always_comb begin
    kind_d     = kind_q;
    cnt_d      = cnt_q;
    xor_d      = xor_q;
    await_d    = await_q;
    exceed_d   = exceed_q;
    kind       = kind_q;
    pos        = '0;
    start      = 1'b0;
    fin        = 1'b0;
    good       = 1'b0;
    ovf        = 1'b0;
    expect_sum = xor_q;

    if (kind_q == KIND_NONE) begin
      kind     = classify(b);
      start    = 1'b1;
      xor_d    = '0;
      await_d  = 1'b0;
      exceed_d = 1'b0;
      cnt_d    = '0;
      if (kind == KIND_READY || kind == KIND_IDLE || kind == KIND_ERROR) begin
        fin = 1'b1;
      end else begin
        kind_d = kind;
      end
    end else begin
      if (cnt_q < POS_CAP) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        cnt_d    = POS_CAP;
        exceed_d = 1'b1;
      end
      pos = cnt_d;
      ovf = exceed_d;

      case (kind_q)
        KIND_STATUS: fin = 1'b1;
        KIND_DATA:   fin = (b == BYTE_READY);
        KIND_PACKET: begin
          if (await_q) begin
            // Short packets compare against a fixed marker byte.
            expect_sum = (pos >= CHECK_POS) ? xor_q : BYTE_SHORT;
            good       = (expect_sum == b);
            fin        = 1'b1;
          end else begin
            if (pos >= CHECK_POS) begin
              xor_d = xor_q ^ b;
            end
            if (b == BYTE_ETX || b == BYTE_ETB) begin
              await_d = 1'b1;
            end
          end
        end
        default:     fin = 1'b1;
      endcase

      if (fin) begin
        kind_d   = KIND_NONE;
        cnt_d    = '0;
        xor_d    = '0;
        await_d  = 1'b0;
        exceed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_NONE;
      cnt_q       <= '0;
      xor_q       <= '0;
      await_q     <= 1'b0;
      exceed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        kind_q   <= kind_d;
        cnt_q    <= cnt_d;
        xor_q    <= xor_d;
        await_q  <= await_d;
        exceed_q <= exceed_d;
      end
      if (advance_o) begin
        out_valid_q <= stage_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_o.out_byte      <= b;
      out_o.message_kind  <= kind;
      out_o.position      <= POS_W'(pos);
      out_o.message_start <= start;
      out_o.message_end   <= fin;
      out_o.checksum_good <= good;
      out_o.overflow      <= ovf;
    end
  end

  assign out_o.valid = out_valid_q;
endmodule
`default_nettype wire

// ===== hdl/tmd_checker.sv =====
// Port-level checks of the typed message deframer and their bind.
`default_nettype none
`include "typed_message_deframer_defines.svh"
module tmd_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [tmd_pkg::KIND_W-1:0] message_kind_i,
  input wire logic [tmd_pkg::POS_W-1:0]  position_i,
  input wire logic                      message_start_i,
  input wire logic                      message_end_i,
  input wire logic                      checksum_good_i,
  input wire logic                      overflow_i
);
  import tmd_pkg::*;

  `TMD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(position_i) && $stable(message_kind_i), "stalled result changed")
  `TMD_ASSERT(a_short_msg_ends, out_valid_i && message_start_i && (message_kind_i == KIND_READY || message_kind_i == KIND_IDLE || message_kind_i == KIND_ERROR) |-> message_end_i, "one-byte message not closed")
  `TMD_ASSERT(a_good_on_pkt_end, out_valid_i && checksum_good_i |-> message_end_i && message_kind_i == KIND_PACKET, "checksum flag off packet end")
  `TMD_ASSERT(a_start_pos_zero, out_valid_i && message_start_i |-> position_i == '0 && !overflow_i, "message start not at position zero")
  // one edge of reset has always been seen by then
  `TMD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_i, "result valid in reset")
endmodule

bind typed_message_deframer tmd_checker u_tmd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .message_kind_i  (out_o.message_kind),
  .position_i      (out_o.position),
  .message_start_i (out_o.message_start),
  .message_end_i   (out_o.message_end),
  .checksum_good_i (out_o.checksum_good),
  .overflow_i      (out_o.overflow)
);
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the typed message deframer.
`timescale 1ns / 100ps
module testbench;
  import tmd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  // directed part already holds over a thousand bytes
  localparam int unsigned RANDOM_ITEMS = 260;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    kind_e             kind;
    logic [POS_W-1:0]  pos;
    logic              start;
    logic              msg_end;
    logic              good;
    logic              ovf;
  } echo_t;

  logic clk_i;
  logic rst_ni;

  tmd_byte_if   byte_ch ();
  tmd_result_if echo_ch ();

  typed_message_deframer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (echo_ch)
  );

  logic [BYTE_W-1:0] byte_q[$];
  echo_t             echo_q[$];
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       err_cnt;
  int unsigned       cycle_cnt;
  int unsigned       queued;

  // framing state mirrored from the block
  kind_e             open_kind;
  logic [CNT_W-1:0]  byte_cnt;
  logic [BYTE_W-1:0] xor_acc;
  logic              await_chk;
  logic              len_exceeded;

  function automatic echo_t deframe(input logic [BYTE_W-1:0] b);
    echo_t r;
    kind_e k;
    r = '0;
    r.data = b;
    if (open_kind == KIND_NONE) begin
      case (b)
        BYTE_READY:  k = KIND_READY;
        BYTE_IDLE:   k = KIND_IDLE;
        BYTE_ERROR:  k = KIND_ERROR;
        BYTE_STATUS: k = KIND_STATUS;
        BYTE_PACKET: k = KIND_PACKET;
        default:     k = KIND_DATA;
      endcase
      r.kind = k;
      r.start = 1'b1;
      xor_acc = '0;
      await_chk = 1'b0;
      len_exceeded = 1'b0;
      if (k == KIND_READY || k == KIND_IDLE || k == KIND_ERROR) begin
        r.msg_end = 1'b1;
      end else begin
        open_kind = k;
        byte_cnt = '0;
      end
    end else begin
      r.kind = open_kind;
      if (byte_cnt < POS_CAP) byte_cnt++;
      else len_exceeded = 1'b1;
      r.pos = byte_cnt;
      r.ovf = len_exceeded;
      case (open_kind)
        KIND_STATUS: r.msg_end = 1'b1;
        KIND_DATA:   r.msg_end = (b == BYTE_READY);
        KIND_PACKET: begin
          if (await_chk) begin
            r.good = (((byte_cnt >= CHECK_POS) ? xor_acc : BYTE_SHORT) == b);
            r.msg_end = 1'b1;
          end else begin
            if (byte_cnt >= CHECK_POS) xor_acc ^= b;
            if (b == BYTE_ETX || b == BYTE_ETB) await_chk = 1'b1;
          end
        end
        default: r.msg_end = 1'b1;
      endcase
      if (r.msg_end) begin
        open_kind = KIND_NONE;
        byte_cnt = '0;
        xor_acc = '0;
        await_chk = 1'b0;
        len_exceeded = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    byte_q.push_back(b);
    queued++;
  endtask

  // packet body avoids terminators; checksum correct unless corrupted
  task automatic push_packet(input int n_body, input logic [BYTE_W-1:0] term,
                             input bit corrupt);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    sum = '0;
    push_byte(BYTE_PACKET);
    for (int i = 1; i <= n_body; i++) begin
      do b = 8'($urandom()); while (b == BYTE_ETX || b == BYTE_ETB);
      if (i >= CHECK_OFFSET) sum ^= b;
      push_byte(b);
    end
    if (n_body + 1 >= CHECK_OFFSET) sum ^= term;
    push_byte(term);
    if (n_body + 2 < CHECK_OFFSET) sum = BYTE_SHORT;
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    push_byte(sum);
  endtask

  task automatic push_data(input int n_body);
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom());
    while (b == BYTE_READY || b == BYTE_IDLE || b == BYTE_ERROR ||
           b == BYTE_STATUS || b == BYTE_PACKET);
    push_byte(b);
    for (int i = 0; i < n_body; i++) begin
      do b = 8'($urandom()); while (b == BYTE_READY);
      push_byte(b);
    end
    push_byte(BYTE_READY);
  endtask

  task automatic push_message();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      push_byte(8'($urandom()));
    end else if (pick < 16) begin
      push_byte(BYTE_READY);
    end else if (pick < 21) begin
      push_byte(BYTE_IDLE);
    end else if (pick < 26) begin
      push_byte(BYTE_ERROR);
    end else if (pick < 36) begin
      push_byte(BYTE_STATUS);
      push_byte(8'($urandom()));
    end else if (pick < 75) begin
      push_packet($urandom_range(0, 14), $urandom_range(1) ? BYTE_ETX : BYTE_ETB,
                  $urandom_range(99) < 30);
    end else begin
      push_data($urandom_range(0, 12));
    end
  endtask

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch %s: expected 0x%0h, got 0x%0h", field, want, got);
  endtask

  task automatic compare_echo(input echo_t want, input echo_t got);
    if (got.data !== want.data) report("out_byte", want.data, got.data);
    if (got.kind !== want.kind) report("message_kind", want.kind, got.kind);
    if (got.pos !== want.pos) report("position", want.pos, got.pos);
    if (got.start !== want.start) report("message_start", want.start, got.start);
    if (got.msg_end !== want.msg_end) report("message_end", want.msg_end, got.msg_end);
    if (got.good !== want.good) report("checksum_good", want.good, got.good);
    if (got.ovf !== want.ovf) report("overflow", want.ovf, got.ovf);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ch.valid <= 1'b0;
      byte_ch.data_byte <= '0;
    end else begin
      if (byte_ch.valid && byte_ch.ready)
        echo_q.push_back(deframe(byte_ch.data_byte));
      if (!byte_ch.valid || byte_ch.ready) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          byte_ch.data_byte <= byte_q.pop_front();
          byte_ch.valid <= 1'b1;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    echo_t got;
    if (!rst_ni) begin
      echo_ch.ready <= 1'b0;
    end else begin
      if (echo_ch.valid && echo_ch.ready) begin
        got = {echo_ch.out_byte, kind_e'(echo_ch.message_kind), echo_ch.position,
               echo_ch.message_start, echo_ch.message_end, echo_ch.checksum_good,
               echo_ch.overflow};
        if (echo_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result: out_byte 0x%0h", got.data);
        end else begin
          compare_echo(echo_q.pop_front(), got);
        end
      end
      echo_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    phase_idle = '{0, 58, 0, 9};
    phase_stall = '{0, 0, 58, 9};
    rst_ni = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    echo_ch.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    err_cnt = 0;
    queued = 0;
    open_kind = KIND_NONE;
    byte_cnt = '0;
    xor_acc = '0;
    await_chk = 1'b0;
    len_exceeded = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // one-byte messages, status payloads including control codes
    push_byte(BYTE_READY);
    push_byte(BYTE_IDLE);
    push_byte(BYTE_ERROR);
    push_byte(BYTE_STATUS);
    push_byte(8'h00);
    push_byte(BYTE_STATUS);
    push_byte(8'hff);
    push_byte(BYTE_STATUS);
    push_byte(BYTE_READY);
    // short packets: checksum compared with the fixed short value
    push_packet(0, BYTE_ETX, 1'b0);
    push_packet(1, BYTE_ETB, 1'b1);
    // terminator right before the check offset, and longer packets
    push_packet(4, BYTE_ETX, 1'b0);
    push_packet(8, BYTE_ETB, 1'b0);
    push_packet(8, BYTE_ETX, 1'b1);
    // data: highest first byte, control bytes inside the body
    push_byte(8'hff);
    push_byte(BYTE_READY);
    push_byte(8'h41);
    push_byte(BYTE_STATUS);
    push_byte(BYTE_PACKET);
    push_byte(BYTE_ETX);
    push_byte(BYTE_READY);
    // length saturation, then terminator and checksum still handled
    push_packet(MAX_MESSAGE + 6, BYTE_ETB, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      while (byte_q.size() > 0) @(negedge clk_i);
      idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      queued = 0;
      while (queued < RANDOM_ITEMS / 4) push_message();
    end
    while (byte_q.size() > 0 || byte_ch.valid) @(negedge clk_i);
    while (echo_q.size() > 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (echo_q.size() > 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
